[src/pasr_pkg.sv]
// Shared types and constants for the point-add range-sum tree.
package pasr_pkg;

  localparam int OPC_W = 1;
  localparam int IDX_W = 10;
  localparam int SUM_W = 64;

  typedef logic [OPC_W-1:0] pasr_opc_t;

  localparam pasr_opc_t OP_ADD   = 1'b0;
  localparam pasr_opc_t OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_A,
    ST_Q_B,
    ST_Q_DONE
  } pasr_state_t;

endpackage

[src/pasr_ram.sv]
// Generic single-port RAM with a registered read.
module pasr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/point_add_range_sum_tree.sv]
// Top level of the point-add range-sum tree: sequencer around one node-sum RAM.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  in_opcode, in_index_low, in_index_high, in_add_value
//   out      out  out_valid/out_stall out_range_sum
//
// Both walks begin once the item is accepted in ST_IDLE. An add walks from its leaf
// to the root, reading each level and then writing it back. A query walks the range
// level by level in ST_Q_A and ST_Q_B, closes the sum in ST_Q_A and then loads the
// output register in ST_Q_DONE; the single RAM port paces both walks.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per cycle,
// while in_stall is held high. A finished sum waits in the output register, so
// the next item is taken while out_stall holds the previous result.
module point_add_range_sum_tree #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pasr_pkg::OPC_W-1:0]    in_opcode,
  input  logic [pasr_pkg::IDX_W-1:0]    in_index_low,
  input  logic [pasr_pkg::IDX_W-1:0]    in_index_high,
  input  logic signed [pasr_pkg::SUM_W-1:0] in_add_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [pasr_pkg::SUM_W-1:0] out_range_sum
);

  import pasr_pkg::*;

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;

  pasr_state_t state_r, state_nxt;

  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [NW-1:0]    a_r, a_nxt;
  logic [NW-1:0]    b_r, b_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] val_r, val_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [SUM_W-1:0] mem_wdata;
  logic [SUM_W-1:0] mem_rdata;

  logic [31:0]      lo32, hi32, hi_clip;
  logic             q_empty;
  logic [SUM_W-1:0] acc_sum;
  logic [NW-1:0]    b_dec;
  logic [AW-1:0]    k_shift;

  pasr_ram #(
    .WIDTH(SUM_W),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign lo32    = 32'(in_index_low);
  assign hi32    = 32'(in_index_high);
  assign hi_clip = (hi32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : hi32;
  // An empty or out-of-range query starts with a == b, so the walk ends at once.
  assign q_empty = lo32 > hi_clip;
  assign acc_sum = acc_r + (pend_r ? mem_rdata : '0);
  assign b_dec   = b_r - 1'b1;
  assign k_shift = k_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    val_nxt       = val_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    out_sum_nxt   = out_sum_r;
    mem_we        = 1'b0;
    mem_addr      = k_r;
    mem_wdata     = mem_rdata + val_r;
    in_stall      = 1'b1;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_opcode)
            OP_ADD: begin
              // A position beyond the tree is dropped without effect.
              if (lo32 < 32'(LEAVES)) begin
                k_nxt     = AW'(lo32 + 32'(LEAVES));
                val_nxt   = in_add_value;
                state_nxt = ST_ADD_RD;
              end
            end
            OP_QUERY: begin
              a_nxt     = q_empty ? '0 : NW'(lo32 + 32'(LEAVES));
              b_nxt     = q_empty ? '0 : NW'(hi_clip + 32'(LEAVES) + 32'd1);
              acc_nxt   = '0;
              state_nxt = ST_Q_A;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        mem_addr  = k_r;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = k_r;
        mem_wdata = mem_rdata + val_r;
        k_nxt     = k_shift;
        state_nxt = (k_shift == '0) ? ST_IDLE : ST_ADD_RD;
      end
      ST_Q_A: begin
        acc_nxt = acc_sum;
        if (a_r >= b_r) begin
          state_nxt = ST_Q_DONE;
        end else begin
          if (a_r[0]) begin
            mem_addr = a_r[AW-1:0];
            a_nxt    = a_r + 1'b1;
            pend_nxt = 1'b1;
          end
          state_nxt = ST_Q_B;
        end
      end
      ST_Q_B: begin
        acc_nxt = acc_sum;
        if (b_r[0]) begin
          mem_addr = b_dec[AW-1:0];
          pend_nxt = 1'b1;
        end
        // For odd b, (b - 1) >> 1 equals b >> 1.
        a_nxt     = a_r >> 1;
        b_nxt     = b_r >> 1;
        state_nxt = ST_Q_A;
      end
      ST_Q_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    val_r     <= val_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

`ifndef SYNTH
  // The RAM is written only by the clearing pass and the add write-back.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_ADD_WR))
    else $error("node RAM written outside clear or add write-back");

  // A pending read result is consumed only by the query walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_Q_A || state_r == ST_Q_B))
    else $error("pending read data outside the query walk");

  // The add walk never reads the unused node zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_RD) |-> (k_r != '0))
    else $error("add walk reached node zero");

  // A finished query lands in the output register once it is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_DONE && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("finished query sum not presented");
`endif

endmodule
